FILE: hw/rtl/bgd_pkg.sv
`default_nettype none

package bgd_pkg;

   typedef enum logic [2:0] {
      GESTURE_NONE   = 3'd0,
      GESTURE_SHORT  = 3'd1,
      GESTURE_DOUBLE = 3'd2,
      GESTURE_TRIPLE = 3'd3,
      GESTURE_LONG1  = 3'd4,
      GESTURE_LONG2  = 3'd5
   } gesture_type;

   typedef enum logic [1:0] {
      CSR_DEBOUNCE    = 2'd0,
      CSR_CLICK_WIN   = 2'd1,
      CSR_LONG_FIRST  = 2'd2,
      CSR_LONG_SECOND = 2'd3
   } csr_index_type;

   localparam int unsigned CFG_WIDTH = 16;
   localparam int unsigned DT_WIDTH  = 16;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET    = 16'd50;
   localparam logic [CFG_WIDTH-1:0] CLICK_WIN_RESET   = 16'd400;
   localparam logic [CFG_WIDTH-1:0] LONG_FIRST_RESET  = 16'd2000;
   localparam logic [CFG_WIDTH-1:0] LONG_SECOND_RESET = 16'd5000;

   // single-bit and tally state of the detector
   typedef struct packed {
      logic       candidate_level;
      logic       stable_level;
      logic       first_long_sent;
      logic       second_long_sent;
      logic       clicks_waiting;
      logic [1:0] click_tally;
   } flags_type;

endpackage

`default_nettype wire

FILE: hw/rtl/bgd_core.sv
`default_nettype none

module bgd_core #(
   parameter int unsigned TIME_WIDTH = 16
) (
   input  wire logic [bgd_pkg::CFG_WIDTH-1:0] debounce_time,
   input  wire logic [bgd_pkg::CFG_WIDTH-1:0] click_window,
   input  wire logic [bgd_pkg::CFG_WIDTH-1:0] long_hold_first,
   input  wire logic [bgd_pkg::CFG_WIDTH-1:0] long_hold_second,
   input  wire logic                          raw_level,
   input  wire logic [bgd_pkg::DT_WIDTH-1:0]  elapsed_time,
   input  wire bgd_pkg::flags_type            flags_cur,
   input  wire logic [TIME_WIDTH-1:0]         candidate_time_cur,
   input  wire logic [TIME_WIDTH-1:0]         held_time_cur,
   input  wire logic [TIME_WIDTH-1:0]         release_time_cur,
   output bgd_pkg::flags_type                 flags_nxt,
   output logic [TIME_WIDTH-1:0]              candidate_time_nxt,
   output logic [TIME_WIDTH-1:0]              held_time_nxt,
   output logic [TIME_WIDTH-1:0]              release_time_nxt,
   output bgd_pkg::gesture_type               gesture
);

   // wide enough for a saturating sum and for second threshold of first + 1
   localparam int unsigned W = (TIME_WIDTH + 1 > bgd_pkg::CFG_WIDTH + 1) ?
                               TIME_WIDTH + 1 : bgd_pkg::CFG_WIDTH + 1;
   localparam logic [W-1:0] TMAX_W = {{(W-TIME_WIDTH){1'b0}}, {TIME_WIDTH{1'b1}}};

   logic [W-1:0]          dt_w;
   logic [W-1:0]          dt_sat;
   logic [W-1:0]          deb_w;
   logic [W-1:0]          win_w;
   logic [W-1:0]          first_w;
   logic [W-1:0]          second_raw_w;
   logic [W-1:0]          second_w;
   logic [TIME_WIDTH-1:0] rel_sum;

   function automatic logic [TIME_WIDTH-1:0] sat_add(input logic [W-1:0] a,
                                                      input logic [W-1:0] b);
      logic [W-1:0] s;
      s = a + b;
      return (s > TMAX_W) ? TMAX_W[TIME_WIDTH-1:0] : s[TIME_WIDTH-1:0];
   endfunction

   function automatic logic [W-1:0] at_least_one(input logic [bgd_pkg::CFG_WIDTH-1:0] v);
      return (v == '0) ? W'(1) : W'(v);
   endfunction

   assign dt_w         = W'(elapsed_time);
   assign dt_sat       = (dt_w > TMAX_W) ? TMAX_W : dt_w;
   assign deb_w        = at_least_one(debounce_time);
   assign win_w        = at_least_one(click_window);
   assign first_w      = at_least_one(long_hold_first);
   assign second_raw_w = W'(long_hold_second);
   assign second_w     = (second_raw_w > first_w) ? second_raw_w : first_w + W'(1);
   assign rel_sum      = sat_add(W'(release_time_cur), dt_sat);

   always_comb begin
      flags_nxt          = flags_cur;
      candidate_time_nxt = candidate_time_cur;
      held_time_nxt      = held_time_cur;
      release_time_nxt   = release_time_cur;
      gesture            = bgd_pkg::GESTURE_NONE;

      if (elapsed_time != '0) begin
         flags_nxt.candidate_level = raw_level;
         if (raw_level != flags_cur.candidate_level) begin
            candidate_time_nxt = dt_sat[TIME_WIDTH-1:0];
         end else begin
            candidate_time_nxt = sat_add(W'(candidate_time_cur), dt_sat);
         end

         if (raw_level != flags_cur.stable_level && W'(candidate_time_nxt) >= deb_w) begin
            flags_nxt.stable_level = raw_level;
            if (raw_level) begin
               // debounced press
               held_time_nxt              = '0;
               flags_nxt.first_long_sent  = 1'b0;
               flags_nxt.second_long_sent = 1'b0;
            end else if (!flags_cur.first_long_sent && held_time_cur != '0) begin
               release_time_nxt = '0;
               if (flags_cur.click_tally == 2'd2) begin
                  // third click reports at once
                  flags_nxt.clicks_waiting = 1'b0;
                  flags_nxt.click_tally    = 2'd0;
                  gesture                  = bgd_pkg::GESTURE_TRIPLE;
               end else begin
                  flags_nxt.clicks_waiting = 1'b1;
                  flags_nxt.click_tally    = flags_cur.click_tally + 2'd1;
               end
            end else begin
               // release after long press or with no hold time
               flags_nxt.clicks_waiting = 1'b0;
               flags_nxt.click_tally    = 2'd0;
               release_time_nxt         = '0;
            end
         end else if (flags_cur.stable_level) begin
            held_time_nxt = sat_add(W'(held_time_cur), dt_sat);
            if (!flags_cur.first_long_sent && W'(held_time_nxt) >= first_w) begin
               flags_nxt.first_long_sent = 1'b1;
               flags_nxt.clicks_waiting  = 1'b0;
               flags_nxt.click_tally     = 2'd0;
               release_time_nxt          = '0;
               gesture                   = bgd_pkg::GESTURE_LONG1;
            end else if (!flags_cur.second_long_sent && W'(held_time_nxt) >= second_w) begin
               flags_nxt.second_long_sent = 1'b1;
               gesture                    = bgd_pkg::GESTURE_LONG2;
            end
         end else if (flags_cur.clicks_waiting && !raw_level) begin
            if (W'(rel_sum) >= win_w) begin
               gesture = (flags_cur.click_tally == 2'd2) ? bgd_pkg::GESTURE_DOUBLE
                                                         : bgd_pkg::GESTURE_SHORT;
               flags_nxt.clicks_waiting = 1'b0;
               flags_nxt.click_tally    = 2'd0;
               release_time_nxt         = '0;
            end else begin
               release_time_nxt = rel_sum;
            end
         end
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/button_gesture_detector_top.sv
// path: an accepted request goes into the input register, then the state update
//   writes the result register; a stall on rsp_ready can hold it between the two
// throughput: one request per cycle while rsp_ready does not stall the result register
// reset: synchronous, active high; clears all detector state and both valid
//   flags and restores the default configuration values
`default_nettype none

module button_gesture_detector_top #(
   parameter int unsigned TIME_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_raw_level,
   input  wire logic [bgd_pkg::DT_WIDTH-1:0]  req_elapsed_time,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [2:0]                         rsp_gesture,
   input  wire logic                          csr_we,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [bgd_pkg::CFG_WIDTH-1:0] csr_wdata
);

   logic [bgd_pkg::CFG_WIDTH-1:0] debounce_ff;
   logic [bgd_pkg::CFG_WIDTH-1:0] click_win_ff;
   logic [bgd_pkg::CFG_WIDTH-1:0] long_first_ff;
   logic [bgd_pkg::CFG_WIDTH-1:0] long_second_ff;

   logic                          in_valid_ff;
   logic                          raw_ff;
   logic [bgd_pkg::DT_WIDTH-1:0]  dt_ff;

   bgd_pkg::flags_type            flags_ff;
   bgd_pkg::flags_type            flags_in;
   logic [TIME_WIDTH-1:0]         cand_time_ff;
   logic [TIME_WIDTH-1:0]         cand_time_in;
   logic [TIME_WIDTH-1:0]         held_time_ff;
   logic [TIME_WIDTH-1:0]         held_time_in;
   logic [TIME_WIDTH-1:0]         rel_time_ff;
   logic [TIME_WIDTH-1:0]         rel_time_in;

   logic                          rsp_valid_ff;
   bgd_pkg::gesture_type          gesture_ff;
   bgd_pkg::gesture_type          gesture_in;

   logic                          advance;
   logic                          step;

   assign advance   = rsp_ready || !rsp_valid_ff;
   assign req_ready = !in_valid_ff || advance;
   assign step      = in_valid_ff && advance;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_gesture = gesture_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff    <= bgd_pkg::DEBOUNCE_RESET;
         click_win_ff   <= bgd_pkg::CLICK_WIN_RESET;
         long_first_ff  <= bgd_pkg::LONG_FIRST_RESET;
         long_second_ff <= bgd_pkg::LONG_SECOND_RESET;
      end else if (csr_we) begin
         unique case (bgd_pkg::csr_index_type'(csr_index))
            bgd_pkg::CSR_DEBOUNCE:    debounce_ff    <= csr_wdata;
            bgd_pkg::CSR_CLICK_WIN:   click_win_ff   <= csr_wdata;
            bgd_pkg::CSR_LONG_FIRST:  long_first_ff  <= csr_wdata;
            bgd_pkg::CSR_LONG_SECOND: long_second_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         raw_ff <= req_raw_level;
         dt_ff  <= req_elapsed_time;
      end
   end

   bgd_core #(
      .TIME_WIDTH(TIME_WIDTH)
   ) u_core (
      .debounce_time      (debounce_ff),
      .click_window       (click_win_ff),
      .long_hold_first    (long_first_ff),
      .long_hold_second   (long_second_ff),
      .raw_level          (raw_ff),
      .elapsed_time       (dt_ff),
      .flags_cur          (flags_ff),
      .candidate_time_cur (cand_time_ff),
      .held_time_cur      (held_time_ff),
      .release_time_cur   (rel_time_ff),
      .flags_nxt          (flags_in),
      .candidate_time_nxt (cand_time_in),
      .held_time_nxt      (held_time_in),
      .release_time_nxt   (rel_time_in),
      .gesture            (gesture_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= '0;
         cand_time_ff <= '0;
         held_time_ff <= '0;
         rel_time_ff  <= '0;
      end else if (step) begin
         flags_ff     <= flags_in;
         cand_time_ff <= cand_time_in;
         held_time_ff <= held_time_in;
         rel_time_ff  <= rel_time_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         gesture_ff <= gesture_in;
      end
   end

`ifndef SYNTHESIS
   // idle click state carries no tally or window time
   assert property (@(posedge clock) disable iff (reset)
      !flags_ff.clicks_waiting |-> (flags_ff.click_tally == 2'd0 && rel_time_ff == '0))
      else $error("click tally or window time set with no clicks waiting");

   // the third click always reports at once, so the tally never reaches three
   assert property (@(posedge clock) disable iff (reset)
      flags_ff.click_tally != 2'd3)
      else $error("click tally reached three");

   // the second long press can only follow the first
   assert property (@(posedge clock) disable iff (reset)
      flags_ff.second_long_sent |-> flags_ff.first_long_sent)
      else $error("second long press sent before the first");

   // a result appears only after a request was stepped
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step))
      else $error("result valid without a stepped request");
`endif

endmodule

`default_nettype wire
